>>> sv/lru_pkg.sv
`timescale 1ns / 1ps

package lru_pkg;

	localparam int KEY_W     = 32;
	localparam int VAL_W     = 32;
	localparam int CAP_W     = 5;
	localparam int CAP_RESET = 16;

	localparam logic MODE_GET = 1'b0;
	localparam logic MODE_PUT = 1'b1;

	localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};

endpackage

>>> sv/lru_key_value_cache.sv
`timescale 1ns / 1ps

// Fully associative key/value cache with least-recently-used replacement.
// Each transfer on the slave side is a get (tuser 0) or a put (tuser 1) and
// yields exactly one result transfer. Each operation makes one pass over
// the key memory to find the key, a free slot and the least recent entry,
// then, unless it is a get that misses, a read-modify-write pass over the
// rank memory, one entry per cycle in each pass. The next operation is
// accepted while a result waits in the output register. The user must write
// the capacity register through the cfg channel only while the cache is idle;
// the block does not enforce it. Zero acts as one and values above ENTRIES
// act as ENTRIES.

module lru_key_value_cache #(
	parameter int ENTRIES = 16
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         s_tvalid,
	output logic                                         s_tready,
	// key [31:0], value [63:32]
	input  logic [lru_pkg::KEY_W+lru_pkg::VAL_W-1:0]    s_tdata,
	// mode [0]
	input  logic                                         s_tuser,
	output logic                                         m_tvalid,
	input  logic                                         m_tready,
	// read_value [31:0], victim_key [63:32]
	output logic [lru_pkg::VAL_W+lru_pkg::KEY_W-1:0]    m_tdata,
	// hit [0], evicted [1]
	output logic [1:0]                                   m_tuser,
	input  logic                                         cfg_valid,
	output logic                                         cfg_ready,
	input  logic [lru_pkg::CAP_W-1:0]                    cfg_data
);

	localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW   = $clog2(ENTRIES + 1);
	localparam int CMPW = (CW > lru_pkg::CAP_W) ? CW : lru_pkg::CAP_W;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_UPDATE = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	logic [2:0]                  state_q;
	logic [CW-1:0]               cnt_q;
	logic                        chk_v_s1;
	logic [IW-1:0]               chk_idx_s1;
	logic [CW-1:0]               count_q;
	logic [lru_pkg::CAP_W-1:0]   cap_q;

	logic                        mode_q;
	logic [lru_pkg::KEY_W-1:0]   key_q;
	logic [lru_pkg::VAL_W-1:0]   value_q;

	logic                        hit_q;
	logic [IW-1:0]               hit_idx_q;
	logic [lru_pkg::VAL_W-1:0]   hit_val_q;
	logic [IW-1:0]               hit_rank_q;
	logic                        free_found_q;
	logic [IW-1:0]               free_idx_q;
	logic                        lru_found_q;
	logic [IW-1:0]               lru_idx_q;
	logic [IW-1:0]               lru_rank_q;
	logic [lru_pkg::KEY_W-1:0]   lru_key_q;

	logic [IW-1:0]               slot_q;
	logic [IW:0]                 limit_q;

	logic                        res_hit_q;
	logic                        res_ev_q;
	logic [lru_pkg::VAL_W-1:0]   res_val_q;
	logic [lru_pkg::KEY_W-1:0]   res_evk_q;

	logic                        out_valid_q;
	logic                        out_hit_q;
	logic                        out_ev_q;
	logic [lru_pkg::VAL_W-1:0]   out_val_q;
	logic [lru_pkg::KEY_W-1:0]   out_evk_q;

	logic                        in_xfer;
	logic                        cfg_xfer;
	logic                        issue;
	logic                        scanning;
	logic                        pass_end;
	logic                        out_load;
	logic                        is_put;
	logic                        has_room;
	logic [IW-1:0]               dec_slot;
	logic [CMPW-1:0]             cap_ext;
	logic [CMPW-1:0]             ent_ext;
	logic [CMPW-1:0]             eff_cap;

	logic [lru_pkg::KEY_W-1:0]   rd_key;
	logic [lru_pkg::VAL_W-1:0]   rd_value;
	logic [IW-1:0]               rd_rank;
	logic                        rd_valid;

	logic                        scan_hit;
	logic                        scan_free;
	logic                        scan_lru;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_xfer   = s_tvalid && s_tready;
	assign cfg_xfer  = cfg_valid && cfg_ready;

	assign issue    = ((state_q == ST_SCAN) || (state_q == ST_UPDATE))
		&& (cnt_q < CW'(ENTRIES));
	assign scanning = (state_q == ST_SCAN) && chk_v_s1;
	assign pass_end = !issue && chk_v_s1;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_tready);

	assign scan_hit  = scanning && rd_valid && (rd_key == key_q) && !hit_q;
	assign scan_free = scanning && !rd_valid && !free_found_q;
	assign scan_lru  = scanning && rd_valid && (!lru_found_q || (rd_rank > lru_rank_q));

	assign cap_ext = CMPW'(cap_q);
	assign ent_ext = CMPW'(ENTRIES);
	always_comb begin
		if (cap_ext == '0) begin
			eff_cap = CMPW'(1);
		end else if (cap_ext > ent_ext) begin
			eff_cap = ent_ext;
		end else begin
			eff_cap = cap_ext;
		end
	end

	assign is_put   = (mode_q == lru_pkg::MODE_PUT);
	assign has_room = CMPW'(count_q) < eff_cap;
	assign dec_slot = hit_q ? hit_idx_q : (has_room ? free_idx_q : lru_idx_q);

	lru_kv_store #(
		.ENTRIES (ENTRIES)
	) u_kv_store (
		.clk      (clk),
		.rd_en    (issue && (state_q == ST_SCAN)),
		.rd_addr  (cnt_q[IW-1:0]),
		.rd_key   (rd_key),
		.rd_value (rd_value),
		.wr_en    ((state_q == ST_DECIDE) && is_put),
		.wr_addr  (dec_slot),
		.wr_key   (key_q),
		.wr_value (value_q)
	);

	lru_rank_store #(
		.ENTRIES (ENTRIES)
	) u_rank_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (issue),
		.rd_addr  (cnt_q[IW-1:0]),
		.rd_rank  (rd_rank),
		.rd_valid (rd_valid),
		.wb_en    ((state_q == ST_UPDATE) && chk_v_s1),
		.wb_addr  (chk_idx_s1),
		.slot     (slot_q),
		.limit    (limit_q),
		.set_en   ((state_q == ST_DECIDE) && is_put && !hit_q),
		.set_addr (dec_slot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			chk_v_s1     <= 1'b0;
			count_q      <= '0;
			cap_q        <= lru_pkg::CAP_W'(lru_pkg::CAP_RESET);
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			lru_found_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_xfer) begin
				cap_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (scan_hit) begin
				hit_q <= 1'b1;
			end
			if (scan_free) begin
				free_found_q <= 1'b1;
			end
			if (scan_lru) begin
				lru_found_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						cnt_q        <= '0;
						chk_v_s1     <= 1'b0;
						hit_q        <= 1'b0;
						free_found_q <= 1'b0;
						lru_found_q  <= 1'b0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN, ST_UPDATE: begin
					if (issue) begin
						cnt_q <= cnt_q + CW'(1);
					end
					chk_v_s1 <= issue;
					if (pass_end) begin
						state_q <= (state_q == ST_SCAN) ? ST_DECIDE : ST_DONE;
					end
				end
				ST_DECIDE: begin
					cnt_q <= '0;
					if (is_put && !hit_q && has_room) begin
						count_q <= count_q + CW'(1);
					end
					state_q <= (hit_q || is_put) ? ST_UPDATE : ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mode_q  <= s_tuser;
			key_q   <= s_tdata[lru_pkg::KEY_W-1:0];
			value_q <= s_tdata[lru_pkg::KEY_W +: lru_pkg::VAL_W];
		end
		if (issue) begin
			chk_idx_s1 <= cnt_q[IW-1:0];
		end
		if (scan_hit) begin
			hit_idx_q  <= chk_idx_s1;
			hit_val_q  <= rd_value;
			hit_rank_q <= rd_rank;
		end
		if (scan_free) begin
			free_idx_q <= chk_idx_s1;
		end
		if (scan_lru) begin
			lru_idx_q  <= chk_idx_s1;
			lru_rank_q <= rd_rank;
			lru_key_q  <= rd_key;
		end
		if (state_q == ST_DECIDE) begin
			slot_q    <= dec_slot;
			limit_q   <= hit_q ? {1'b0, hit_rank_q} : (IW + 1)'(ENTRIES);
			res_hit_q <= hit_q;
			res_ev_q  <= is_put && !hit_q && !has_room;
			if (is_put) begin
				res_val_q <= '0;
			end else if (hit_q) begin
				res_val_q <= hit_val_q;
			end else begin
				res_val_q <= lru_pkg::MISS_VALUE;
			end
			res_evk_q <= (is_put && !hit_q && !has_room) ? lru_key_q : '0;
		end
		if (out_load) begin
			out_hit_q <= res_hit_q;
			out_ev_q  <= res_ev_q;
			out_val_q <= res_val_q;
			out_evk_q <= res_evk_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_evk_q, out_val_q};
	assign m_tuser  = {out_ev_q, out_hit_q};

endmodule

>>> sv/lru_kv_store.sv
`timescale 1ns / 1ps

module lru_kv_store #(
	parameter int ENTRIES = 16,
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic                          clk,
	input  logic                          rd_en,
	input  logic [IW-1:0]                 rd_addr,
	output logic [lru_pkg::KEY_W-1:0]     rd_key,
	output logic [lru_pkg::VAL_W-1:0]     rd_value,
	input  logic                          wr_en,
	input  logic [IW-1:0]                 wr_addr,
	input  logic [lru_pkg::KEY_W-1:0]     wr_key,
	input  logic [lru_pkg::VAL_W-1:0]     wr_value
);

	logic [lru_pkg::KEY_W-1:0] key_mem [ENTRIES];
	logic [lru_pkg::VAL_W-1:0] val_mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
			val_mem[wr_addr] <= wr_value;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_key   <= key_mem[rd_addr];
			rd_value <= val_mem[rd_addr];
		end
	end

endmodule

>>> sv/lru_rank_store.sv
`timescale 1ns / 1ps

module lru_rank_store #(
	parameter int ENTRIES = 16,
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [IW-1:0] rd_addr,
	output logic [IW-1:0] rd_rank,
	output logic          rd_valid,
	input  logic          wb_en,
	input  logic [IW-1:0] wb_addr,
	input  logic [IW-1:0] slot,
	input  logic [IW:0]   limit,
	input  logic          set_en,
	input  logic [IW-1:0] set_addr
);

	logic [IW-1:0]      rank_mem [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [IW-1:0]      new_rank;

	// most recent goes to zero, younger valid entries age by one
	always_comb begin
		if (wb_addr == slot) begin
			new_rank = '0;
		end else if (rd_valid && ({1'b0, rd_rank} < limit)) begin
			new_rank = rd_rank + IW'(1);
		end else begin
			new_rank = rd_rank;
		end
	end

	always_ff @(posedge clk) begin
		if (wb_en) begin
			rank_mem[wb_addr] <= new_rank;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_rank <= rank_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_valid <= 1'b0;
		end else begin
			if (set_en) begin
				valid_q[set_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid <= valid_q[rd_addr];
			end
		end
	end

endmodule

>>> bench/lru_key_value_cache_tb.sv
`timescale 1ns / 1ps

module lru_key_value_cache_tb;

	localparam int ENTRIES  = 16;
	localparam int RANK_W   = $clog2(ENTRIES);
	localparam int KW       = lru_pkg::KEY_W;
	localparam int VW       = lru_pkg::VAL_W;
	localparam int CPW      = lru_pkg::CAP_W;
	localparam int WATCHDOG = 4000;
	localparam int RX_HOLD  = 400;

	typedef struct packed {
		logic          hit;
		logic [VW-1:0] read_value;
		logic          evicted;
		logic [KW-1:0] victim_key;
	} cache_reply_t;

	class cache_mirror;
		logic [KW-1:0]     keys[ENTRIES];
		logic [VW-1:0]     vals[ENTRIES];
		bit                valid[ENTRIES];
		logic [RANK_W-1:0] rank[ENTRIES];
		logic [CPW-1:0]    count;
		logic [CPW-1:0]    capacity;
		cache_reply_t      pending_replies[$];
		int                errors;
		int                replies_seen;
		int                hits;
		int                evictions;
		int                cap_writes;

		function new();
			for (int i = 0; i < ENTRIES; i++) begin
				keys[i]  = '0;
				vals[i]  = '0;
				valid[i] = 1'b0;
				rank[i]  = '0;
			end
			count        = '0;
			capacity     = CPW'(lru_pkg::CAP_RESET);
			errors       = 0;
			replies_seen = 0;
			hits         = 0;
			evictions    = 0;
			cap_writes   = 0;
		endfunction

		function void write_capacity(logic [CPW-1:0] v);
			capacity = v;
			cap_writes++;
		endfunction

		function logic [CPW-1:0] limit();
			logic [CPW-1:0] c;
			c = capacity;
			if (c < 1)
				c = CPW'(1);
			if (c > ENTRIES)
				c = CPW'(ENTRIES);
			return c;
		endfunction

		// make slot s most recent; younger entries age by one
		function void promote(int s);
			logic [RANK_W-1:0] r;
			r = rank[s];
			for (int i = 0; i < ENTRIES; i++)
				if (valid[i] && i != s && rank[i] < r)
					rank[i]++;
			rank[s] = '0;
		endfunction

		function int oldest_slot();
			int best;
			bit found;
			best  = 0;
			found = 1'b0;
			for (int i = 0; i < ENTRIES; i++)
				if (valid[i] && (!found || rank[i] > rank[best])) begin
					best  = i;
					found = 1'b1;
				end
			return best;
		endfunction

		function void note_op(logic mode, logic [KW-1:0] key, logic [VW-1:0] value);
			cache_reply_t r;
			int found;
			int slot;
			r     = '0;
			found = -1;
			for (int i = 0; i < ENTRIES; i++)
				if (valid[i] && keys[i] == key) begin
					found = i;
					break;
				end
			if (found >= 0) begin
				r.hit = 1'b1;
				hits++;
				if (mode == lru_pkg::MODE_GET)
					r.read_value = vals[found];
				else
					vals[found] = value;
				promote(found);
			end else if (mode == lru_pkg::MODE_GET) begin
				r.read_value = lru_pkg::MISS_VALUE;
			end else begin
				slot = -1;
				if (count < limit())
					for (int i = 0; i < ENTRIES; i++)
						if (!valid[i]) begin
							slot = i;
							break;
						end
				if (slot < 0) begin
					slot = oldest_slot();
					if (valid[slot]) begin
						r.evicted    = 1'b1;
						r.victim_key = keys[slot];
						valid[slot]  = 1'b0;
						count--;
						evictions++;
					end
				end
				for (int i = 0; i < ENTRIES; i++)
					if (valid[i])
						rank[i]++;
				valid[slot] = 1'b1;
				keys[slot]  = key;
				vals[slot]  = value;
				rank[slot]  = '0;
				count++;
			end
			pending_replies.push_back(r);
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
			errors++;
		endtask

		task check_reply(cache_reply_t got);
			cache_reply_t want;
			replies_seen++;
			if (pending_replies.size() == 0) begin
				report("unexpected reply", 32'(got.read_value), 32'hx);
				return;
			end
			want = pending_replies.pop_front();
			if (got.hit !== want.hit)
				report("hit", 32'(got.hit), 32'(want.hit));
			if (got.read_value !== want.read_value)
				report("read_value", got.read_value, want.read_value);
			if (got.evicted !== want.evicted)
				report("evicted", 32'(got.evicted), 32'(want.evicted));
			if (got.victim_key !== want.victim_key)
				report("victim_key", got.victim_key, want.victim_key);
		endtask
	endclass

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [KW+VW-1:0]     s_tdata   = '0;
	logic                 s_tuser   = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [VW+KW-1:0]     m_tdata;
	logic [1:0]           m_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CPW-1:0]       cfg_data  = '0;

	cache_mirror   mirror = new();
	logic [KW-1:0] key_pool[$];
	int            quiet_cycles = 0;
	int            tx_burst = 0;
	int            ops_sent = 0;

	lru_key_value_cache #(
		.ENTRIES(ENTRIES)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cache_reply_t got;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (m_tvalid && m_tready) begin
				got.hit        = m_tuser[0];
				got.evicted    = m_tuser[1];
				got.read_value = m_tdata[VW-1:0];
				got.victim_key = m_tdata[VW+KW-1:VW];
				mirror.check_reply(got);
				moved = 1'b1;
			end
			if (s_tvalid && s_tready) begin
				mirror.note_op(s_tuser, s_tdata[KW-1:0], s_tdata[KW+VW-1:KW]);
				moved = 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				mirror.write_capacity(cfg_data);
				moved = 1'b1;
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG) begin
				$display("%0t ns: no transfer for %0d cycles", $time, WATCHDOG);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// receiver: random stalls, calm stretches, and one long hold-off to back up the input
	initial begin
		int stall_left;
		int calm_left;
		int r;
		bit held;
		stall_left = 0;
		calm_left  = 0;
		held       = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && mirror.replies_seen >= 40) begin
				m_tready <= 1'b0;
				repeat (RX_HOLD) @(negedge clk);
				held = 1'b1;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (calm_left > 0) begin
					calm_left--;
				end else begin
					r = $urandom_range(0, 99);
					if (r < 25)
						stall_left = $urandom_range(1, 3);
					else if (r < 28)
						stall_left = $urandom_range(20, 80);
					else if (r < 30)
						calm_left = 150;
				end
			end
		end
	end

	task automatic issue_op(logic mode, logic [KW-1:0] key, logic [VW-1:0] value);
		int gap;
		int r;
		r = $urandom_range(0, 99);
		if (tx_burst > 0) begin
			gap = 0;
			tx_burst--;
		end else if (r < 55) begin
			gap = 0;
		end else if (r < 90) begin
			gap = $urandom_range(1, 4);
		end else if (r < 96) begin
			gap = $urandom_range(20, 70);
		end else begin
			gap = 0;
			tx_burst = 40;
		end
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {value, key};
		do @(posedge clk); while (!s_tready);
		ops_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (mirror.pending_replies.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_cap(logic [CPW-1:0] v);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] edge_or_random();
		case ($urandom_range(0, 11))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'h0000_0000;
			3:       return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_phase(int n);
		int pool_size;
		logic [KW-1:0] k;
		logic mode;
		pool_size = $urandom_range(2, 28);
		key_pool.delete();
		for (int i = 0; i < pool_size; i++)
			key_pool.push_back(edge_or_random());
		for (int i = 0; i < n; i++) begin
			mode = $urandom_range(0, 1) ? lru_pkg::MODE_PUT : lru_pkg::MODE_GET;
			if ($urandom_range(0, 99) < 85)
				k = key_pool[$urandom_range(0, pool_size - 1)];
			else
				k = $urandom;
			issue_op(mode, k, edge_or_random());
		end
	endtask

	initial begin
		logic [CPW-1:0] caps[8];
		caps = '{5'd31, 5'd1, 5'd16, 5'd0, 5'd5, 5'd2, 5'd0, 5'd31};
		caps[3] = CPW'($urandom_range(0, 31));
		caps[6] = CPW'($urandom_range(0, 31));
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// reset capacity: empty miss, inserts, hits, update, all-ones key and value
		issue_op(lru_pkg::MODE_GET, 32'h0000_0000, 32'h1234_5678);
		issue_op(lru_pkg::MODE_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		issue_op(lru_pkg::MODE_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		issue_op(lru_pkg::MODE_GET, 32'h8000_0000, 32'hFFFF_FFFF);
		issue_op(lru_pkg::MODE_GET, 32'h7FFF_FFFF, 32'h0000_0000);
		issue_op(lru_pkg::MODE_PUT, 32'h8000_0000, 32'h0000_0000);
		issue_op(lru_pkg::MODE_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		issue_op(lru_pkg::MODE_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue_op(lru_pkg::MODE_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		issue_op(lru_pkg::MODE_PUT, 32'h0000_0000, 32'h0000_0000);
		issue_op(lru_pkg::MODE_GET, 32'h0000_0000, 32'hFFFF_FFFF);

		// capacity below the entry count: evict one per new key
		write_cap(5'd2);
		issue_op(lru_pkg::MODE_PUT, 32'h0000_0001, 32'h0000_0001);
		issue_op(lru_pkg::MODE_PUT, 32'h0000_0002, 32'h0000_0002);
		issue_op(lru_pkg::MODE_GET, 32'h8000_0000, 32'h0000_0000);

		// zero capacity acts as one
		write_cap(5'd0);
		issue_op(lru_pkg::MODE_PUT, 32'h0000_0003, 32'h0000_0003);
		issue_op(lru_pkg::MODE_PUT, 32'h0000_0004, 32'h0000_0004);
		issue_op(lru_pkg::MODE_GET, 32'h0000_0003, 32'h0000_0000);

		// capacity above the slot count saturates
		write_cap(5'd31);
		issue_op(lru_pkg::MODE_PUT, 32'h0000_0005, 32'h0000_0005);
		issue_op(lru_pkg::MODE_GET, 32'h0000_0004, 32'h0000_0000);

		foreach (caps[p]) begin
			write_cap(caps[p]);
			random_phase(155);
		end

		drain();
		repeat (2 * ENTRIES + 10) @(posedge clk);
		if (mirror.pending_replies.size() != 0)
			mirror.report("replies still owed", 32'(mirror.pending_replies.size()), 0);
		$display("Sent %0d gets and puts over %0d capacity settings; %0d replies checked.",
			ops_sent, mirror.cap_writes, mirror.replies_seen);
		$display("Seen %0d hits and %0d evictions, with one long output hold-off.",
			mirror.hits, mirror.evictions);
		if (mirror.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

>>> sim.f
sv/lru_pkg.sv
sv/lru_kv_store.sv
sv/lru_rank_store.sv
sv/lru_key_value_cache.sv
bench/lru_key_value_cache_tb.sv
